@@ sv/rfp_pkg.sv @@
// Package with constants shared by the RTP frame packetizer.
package rfp_pkg;

    localparam int unsigned MAX_PACKET_PAYLOAD = 2048;
    localparam int unsigned HEADER_BYTES       = 12;

    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;

    localparam logic [6:0]  PT_RESET       = 7'd26;
    localparam logic [31:0] SSRC_RESET     = 32'd123456;
    localparam logic [31:0] TS_STEP_RESET  = 32'd3600;
    localparam logic [11:0] MAX_PAY_RESET  = 12'd1200;

    typedef enum logic [1:0] {
        REG_PAYLOAD_TYPE   = 2'd0,
        REG_SOURCE_ID      = 2'd1,
        REG_TIMESTAMP_STEP = 2'd2,
        REG_MAX_PAYLOAD    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        BYTE_VERSION = 4'd0,
        BYTE_MARK_PT = 4'd1,
        BYTE_SEQ_HI  = 4'd2,
        BYTE_SEQ_LO  = 4'd3,
        BYTE_TS_3    = 4'd4,
        BYTE_TS_2    = 4'd5,
        BYTE_TS_1    = 4'd6,
        BYTE_TS_0    = 4'd7,
        BYTE_SSRC_3  = 4'd8,
        BYTE_SSRC_2  = 4'd9,
        BYTE_SSRC_1  = 4'd10,
        BYTE_SSRC_0  = 4'd11,
        BYTE_PAYLOAD = 4'd12
    } t_byte_idx;

endpackage

@@ sv/rtp_frame_packetizer.sv @@
// RTP packetizer: frame bytes in, RTP packets with fixed 12-byte header out.
//
// Input stream (s_axis): one payload byte per transaction, with the frame
// length and a frame-start flag in tuser. Output stream (m_axis): the packet
// byte stream, tlast on the final payload byte of each packet.
// Configuration over APB: payload type, SSRC, timestamp step, max payload.
//
// Each accepted byte updates the sequence, timestamp and frame counters in
// the cycle it is accepted and loads the result register. A byte that opens
// a packet yields 13 output bytes (header then payload); any other byte
// yields one output byte, so payload moves at one byte per cycle while the
// receiver is ready, with the 12 header bytes added per packet. Bytes past
// the end of a frame are accepted and dropped. The first output byte is
// presented in the cycle after its input byte is accepted.
// The next input byte is taken in the same cycle as the last output byte of
// the current one leaves. When the receiver stalls, the result register
// holds and the input side stalls once it is full.
// Reset clears all counters, the timestamp and the sequence number, and loads
// the register defaults (payload type 26, SSRC 123456, step 3600, max 1200).
module rtp_frame_packetizer #(
    parameter int unsigned P_MAX_PACKET_PAYLOAD = rfp_pkg::MAX_PACKET_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
    input  logic        s_axis_tuser,   // [0] frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // packet_end

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rfp_pkg::*;

    localparam logic [16:0] MAX_PAY_W = 17'(P_MAX_PACKET_PAYLOAD);
    localparam logic [3:0]  IDX_LAST  = 4'(HEADER_BYTES);

    logic [6:0]  r_pt;
    logic [31:0] r_ssrc;
    logic [31:0] r_ts_step;
    logic [11:0] r_max_pay;

    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [15:0] r_frame_left;
    logic [11:0] r_pkt_left;

    logic        r_v;
    logic [3:0]  r_idx;
    logic [7:0]  r_byte;
    logic        r_end;
    logic        r_marker;
    logic [15:0] r_hdr_seq;
    logic [31:0] r_hdr_ts;

    logic        in_acc;
    logic        out_acc;
    logic        out_done;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    logic [7:0]  in_byte;
    logic [15:0] in_flen;
    logic        in_start;

    logic [11:0] cap;
    logic [31:0] n_ts;
    logic [15:0] n_frame_left;
    logic [11:0] n_pkt_left;
    logic [15:0] frame_sel;
    logic [11:0] pkt_sel;
    logic        is_last;
    logic        need_hdr;
    logic        has_byte;
    logic [11:0] size;

    assign pready   = 1'b1;
    assign reg_idx  = t_reg_idx'(paddr[3:2]);
    assign cfg_wr   = psel & penable & pwrite & pready;

    assign in_byte  = s_axis_tdata[7:0];
    assign in_flen  = s_axis_tdata[23:8];
    assign in_start = s_axis_tuser;

    assign out_acc       = m_axis_tvalid & m_axis_tready;
    assign out_done      = out_acc & (r_idx == IDX_LAST);
    assign s_axis_tready = ~r_v | out_done;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    always_comb begin
        if (r_max_pay == 12'd0) begin
            cap = 12'd1;
        end else if ({5'd0, r_max_pay} > MAX_PAY_W) begin
            cap = MAX_PAY_W[11:0];
        end else begin
            cap = r_max_pay;
        end
    end

    always_comb begin
        n_ts      = in_start ? (r_ts + r_ts_step) : r_ts;
        frame_sel = in_start ? in_flen : r_frame_left;
        pkt_sel   = in_start ? 12'd0 : r_pkt_left;
        has_byte  = (frame_sel != 16'd0);
        need_hdr  = has_byte & (pkt_sel == 12'd0);
        is_last   = (frame_sel <= {4'd0, cap});
        size      = is_last ? frame_sel[11:0] : cap;
        if (!has_byte) begin
            n_pkt_left   = pkt_sel;
            n_frame_left = frame_sel;
        end else begin
            n_pkt_left   = need_hdr ? (size - 12'd1) : (pkt_sel - 12'd1);
            n_frame_left = frame_sel - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt      <= PT_RESET;
            r_ssrc    <= SSRC_RESET;
            r_ts_step <= TS_STEP_RESET;
            r_max_pay <= MAX_PAY_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PAYLOAD_TYPE:   r_pt      <= pwdata[6:0];
                REG_SOURCE_ID:      r_ssrc    <= pwdata;
                REG_TIMESTAMP_STEP: r_ts_step <= pwdata;
                REG_MAX_PAYLOAD:    r_max_pay <= pwdata[11:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAYLOAD_TYPE:   prdata = {25'd0, r_pt};
            REG_SOURCE_ID:      prdata = r_ssrc;
            REG_TIMESTAMP_STEP: prdata = r_ts_step;
            REG_MAX_PAYLOAD:    prdata = {20'd0, r_max_pay};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= 16'd0;
            r_ts         <= 32'd0;
            r_frame_left <= 16'd0;
            r_pkt_left   <= 12'd0;
            r_v          <= 1'b0;
            r_idx        <= 4'd0;
        end else begin
            if (in_acc) begin
                r_ts         <= n_ts;
                r_frame_left <= n_frame_left;
                r_pkt_left   <= n_pkt_left;
                if (need_hdr) begin
                    r_seq <= r_seq + 16'd1;
                end
                r_v   <= has_byte;
                r_idx <= need_hdr ? 4'd0 : IDX_LAST;
            end else if (out_done) begin
                r_v <= 1'b0;
            end else if (out_acc) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte    <= in_byte;
            r_end     <= (n_pkt_left == 12'd0);
            r_marker  <= is_last;
            r_hdr_seq <= r_seq;
            r_hdr_ts  <= n_ts;
        end
    end

    assign m_axis_tvalid = r_v;
    assign m_axis_tlast  = (r_idx == IDX_LAST) & r_end;

    always_comb begin
        case (t_byte_idx'(r_idx))
            BYTE_VERSION: m_axis_tdata = RTP_VERSION_BYTE;
            BYTE_MARK_PT: m_axis_tdata = {r_marker, r_pt};
            BYTE_SEQ_HI:  m_axis_tdata = r_hdr_seq[15:8];
            BYTE_SEQ_LO:  m_axis_tdata = r_hdr_seq[7:0];
            BYTE_TS_3:    m_axis_tdata = r_hdr_ts[31:24];
            BYTE_TS_2:    m_axis_tdata = r_hdr_ts[23:16];
            BYTE_TS_1:    m_axis_tdata = r_hdr_ts[15:8];
            BYTE_TS_0:    m_axis_tdata = r_hdr_ts[7:0];
            BYTE_SSRC_3:  m_axis_tdata = r_ssrc[31:24];
            BYTE_SSRC_2:  m_axis_tdata = r_ssrc[23:16];
            BYTE_SSRC_1:  m_axis_tdata = r_ssrc[15:8];
            BYTE_SSRC_0:  m_axis_tdata = r_ssrc[7:0];
            BYTE_PAYLOAD: m_axis_tdata = r_byte;
            default:      m_axis_tdata = r_byte;
        endcase
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench for the RTP frame packetizer: streams frames in, predicts and checks the packet bytes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned SETTLE_TICKS = 20;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] flen;
        logic        start;
    } t_frame_byte;

    typedef struct packed {
        logic [7:0] value;
        logic       pkt_end;
    } t_rtp_byte;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata   = '0;   // [7:0] data_byte, [23:8] frame_length
    logic        s_axis_tuser   = 1'b0; // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tlast;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [3:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    t_frame_byte frame_bytes_q[$];
    t_rtp_byte   rtp_bytes_q[$];
    int unsigned mismatch_cnt = 0;

    logic [6:0]  cfg_pt      = PT_RESET;
    logic [31:0] cfg_ssrc    = SSRC_RESET;
    logic [31:0] cfg_ts_step = TS_STEP_RESET;
    logic [11:0] cfg_max     = MAX_PAY_RESET;

    logic [15:0] seq_num    = '0;
    logic [31:0] cur_ts     = '0;
    logic [15:0] frame_left = '0;
    logic [10:0] pkt_left   = '0;
    logic        last_pkt   = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    int unsigned rx_cyc         = 0;
    int unsigned rx_seen        = 0;
    int unsigned hold_left      = 0;
    bit          long_hold_done = 1'b0;
    int unsigned cycle_cnt      = 0;

    rtp_frame_packetizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_rtp_byte(logic [7:0] value, logic pkt_end);
        t_rtp_byte b;
        b.value   = value;
        b.pkt_end = pkt_end;
        rtp_bytes_q.push_back(b);
    endfunction

    function automatic void packetize_byte(logic [7:0] data, logic [15:0] flen, logic start);
        int unsigned cap;
        int unsigned size;
        if (start) begin
            cur_ts     = cur_ts + cfg_ts_step;
            frame_left = flen;
            pkt_left   = '0;
            last_pkt   = 1'b0;
        end
        if (frame_left == 0)
            return;
        if (pkt_left == 0) begin
            cap = (cfg_max == 0) ? 1 : cfg_max;
            if (cap > MAX_PACKET_PAYLOAD)
                cap = MAX_PACKET_PAYLOAD;
            size     = (frame_left > cap) ? cap : frame_left;
            last_pkt = (frame_left <= cap);
            push_rtp_byte(RTP_VERSION_BYTE, 1'b0);
            push_rtp_byte({last_pkt, cfg_pt}, 1'b0);
            push_rtp_byte(seq_num[15:8], 1'b0);
            push_rtp_byte(seq_num[7:0], 1'b0);
            push_rtp_byte(cur_ts[31:24], 1'b0);
            push_rtp_byte(cur_ts[23:16], 1'b0);
            push_rtp_byte(cur_ts[15:8], 1'b0);
            push_rtp_byte(cur_ts[7:0], 1'b0);
            push_rtp_byte(cfg_ssrc[31:24], 1'b0);
            push_rtp_byte(cfg_ssrc[23:16], 1'b0);
            push_rtp_byte(cfg_ssrc[15:8], 1'b0);
            push_rtp_byte(cfg_ssrc[7:0], 1'b0);
            seq_num  = seq_num + 16'd1;
            pkt_left = 11'(size - 1);
        end else begin
            pkt_left = pkt_left - 11'd1;
        end
        frame_left = frame_left - 16'd1;
        push_rtp_byte(data, pkt_left == 0);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_frame_byte item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (frame_bytes_q.size() > 0) begin
                item = frame_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {item.flen, item.data};
                s_axis_tuser  <= item.start;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: rotating stall pattern plus one long hold-off.
    always @(posedge i_clk) begin
        rx_cyc++;
        if (m_axis_tvalid && m_axis_tready)
            rx_seen++;
        if (!long_hold_done && rx_seen >= 400 && frame_bytes_q.size() > 0) begin
            hold_left      = 500;
            long_hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_cyc[9:8] == 2'd0) begin
            m_axis_tready <= 1'b1;
        end else if (rx_cyc[9:8] == 2'd1) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else if (rx_cyc[9:8] == 2'd2) begin
            m_axis_tready <= 1'($urandom_range(0, 1));
        end else begin
            m_axis_tready <= ((rx_cyc % 7) < 3);
        end
    end

    // Predict on each input transaction, then check each output transaction.
    always @(posedge i_clk) begin
        t_rtp_byte want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            packetize_byte(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rtp_bytes_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected output: byte %02h last %0b",
                             m_axis_tdata, m_axis_tlast);
            end else begin
                want = rtp_bytes_q.pop_front();
                if (want.value !== m_axis_tdata || want.pkt_end !== m_axis_tlast) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.value, want.pkt_end, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_PAYLOAD_TYPE:   cfg_pt      = value[6:0];
            REG_SOURCE_ID:      cfg_ssrc    = value;
            REG_TIMESTAMP_STEP: cfg_ts_step = value;
            REG_MAX_PAYLOAD:    cfg_max     = value[11:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [6:0] pt, input logic [31:0] ssrc,
                                input logic [31:0] step, input logic [11:0] max_pay);
        apb_write(REG_PAYLOAD_TYPE, {25'd0, pt});
        apb_write(REG_SOURCE_ID, ssrc);
        apb_write(REG_TIMESTAMP_STEP, step);
        apb_write(REG_MAX_PAYLOAD, {20'd0, max_pay});
    endtask

    task automatic push_item(input logic [7:0] data, input logic [15:0] flen, input logic start);
        t_frame_byte item;
        item.data  = data;
        item.flen  = flen;
        item.start = start;
        frame_bytes_q.push_back(item);
    endtask

    task automatic push_stray();
        push_item(8'($urandom), 16'($urandom), 1'b0);
    endtask

    task automatic queue_frame(input logic [15:0] len, input int unsigned n_send);
        for (int unsigned i = 0; i < n_send; i++) begin
            if (i == 0)
                push_item(8'($urandom), len, 1'b1);
            else
                push_item(8'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (frame_bytes_q.size() != 0 || s_axis_tvalid || rtp_bytes_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int unsigned budget);
        int unsigned n;
        int unsigned r;
        int unsigned len;
        int unsigned sent;
        n = 0;
        while (n < budget) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                len = $urandom_range(1, 24);
                queue_frame(16'(len), len);
                n += len;
                if ($urandom_range(0, 4) == 0)
                    push_stray();
            end else if (r < 78) begin
                len  = $urandom_range(2, 24);
                sent = $urandom_range(1, len - 1);
                queue_frame(16'(len), sent);
                n += sent;
            end else if (r < 86) begin
                queue_frame(16'd0, 1);
            end else if (r < 93) begin
                sent = $urandom_range(1, 6);
                queue_frame(16'($urandom_range(0, 65535)), sent);
                n += sent;
            end else begin
                push_stray();
            end
        end
    endtask

    initial begin
        logic [11:0] max_pay;
        int unsigned r;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(8'h11, 16'h0000, 1'b0);
        push_item(8'h22, 16'h0000, 1'b1);
        push_item(8'h33, 16'hFFFF, 1'b0);
        push_item(8'h00, 16'd3, 1'b1);
        push_item(8'hFF, 16'h0000, 1'b0);
        push_item(8'h5A, 16'hFFFF, 1'b0);
        push_item(8'hC3, 16'hFFFF, 1'b0);
        push_item(8'hA5, 16'hFFFF, 1'b1);
        push_item(8'h3C, 16'h0000, 1'b0);
        push_item(8'h01, 16'd2, 1'b1);
        push_item(8'h80, 16'h5555, 1'b0);
        push_item(8'h7F, 16'hAAAA, 1'b0);
        wait_idle();

        write_config(7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd1);
        queue_frame(16'd3, 3);
        wait_idle();

        write_config(7'h00, 32'h0000_0000, 32'h0000_0000, 12'd0);
        queue_frame(16'd2, 2);
        wait_idle();

        write_config(7'h55, 32'hA5A5_5A5A, 32'd1, 12'hFFF);
        queue_frame(16'd2049, 2);
        queue_frame(16'd2048, 2);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                max_pay = 12'($urandom_range(1, 6));
            else if (r < 8)
                max_pay = 12'($urandom_range(7, 40));
            else if (p == 3)
                max_pay = 12'd2048;
            else
                max_pay = 12'($urandom_range(41, 4095));
            write_config(7'($urandom_range(0, 127)), $urandom, $urandom, max_pay);
            run_random_phase(75);
            wait_idle();
        end

        if (mismatch_cnt == 0 && rtp_bytes_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
